### design/lpddr_pkg.sv
// ----------------------------------------------------------------------------
// lpddr_pkg : shared types and constants of the LPDDR device model
// Command codes, burst mode encoding, mode register 2 latency table.
// ----------------------------------------------------------------------------
package lpddr_pkg;

    localparam int MEM_ADDR_BITS = 16;
    localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;
    localparam int DATA_W        = 16;
    localparam int CMD_W         = 10;
    localparam int LAT_W         = 5;
    localparam int POS_W         = 28;

    // low three bits of the high command part
    localparam logic [2:0] CMD_MRW   = 3'd0;
    localparam logic [2:0] CMD_WRITE = 3'd1;
    localparam logic [2:0] CMD_ACT_A = 3'd2;
    localparam logic [2:0] CMD_READ  = 3'd5;
    localparam logic [2:0] CMD_ACT_B = 3'd6;
    localparam logic [2:0] CMD_NOP   = 3'd7;

    localparam logic [7:0]       MR_LATENCY  = 8'h02;
    localparam logic [3:0]       BURST_LEN   = 4'd8;
    localparam logic [LAT_W-1:0] RL_RESET    = 5'd7;
    localparam logic [LAT_W-1:0] WL_RESET    = 5'd3;

    typedef enum logic [2:0] {
        BURST_IDLE  = 3'b001,
        BURST_READ  = 3'b010,
        BURST_WRITE = 3'b100
    } burst_mode_t;

    typedef struct packed {
        logic                     rd;
        logic                     wr;
        logic [MEM_ADDR_BITS-1:0] addr;
    } mem_op_t;

    typedef struct packed {
        logic             hit;
        logic [LAT_W-1:0] rl;
        logic [LAT_W-1:0] wl;
    } latency_sel_t;

    // Mode register 2 latency selection; hit is set only for the field codes in the case list.
    function automatic latency_sel_t mr2_latency(input logic [3:0] val);
        latency_sel_t sel;
        sel = '{hit: 1'b1, rl: 5'd0, wl: 5'd0};
        case (val)
            4'd1:
            begin
                sel.rl = 5'd6;
                sel.wl = 5'd3;
            end
            4'd2:
            begin
                sel.rl = 5'd8;
                sel.wl = 5'd5;
            end
            4'd3:
            begin
                sel.rl = 5'd10;
                sel.wl = 5'd5;
            end
            4'd4:
            begin
                sel.rl = 5'd12;
                sel.wl = 5'd7;
            end
            4'd5:
            begin
                sel.rl = 5'd14;
                sel.wl = 5'd9;
            end
            4'd6:
            begin
                sel.rl = 5'd16;
                sel.wl = 5'd9;
            end
            default: sel.hit = 1'b0;
        endcase
        return sel;
    endfunction

endpackage

### design/lpddr_ram.sv
// ----------------------------------------------------------------------------
// lpddr_ram : generic simple dual-port RAM
// One write port, one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module lpddr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/lpddr_ctrl.sv
// ----------------------------------------------------------------------------
// lpddr_ctrl : command decode, latency count and burst address generation
// Updates the device state once per accepted word; flags the memory access.
// ----------------------------------------------------------------------------
module lpddr_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic                         edge_phase,
    input  logic [lpddr_pkg::CMD_W-1:0]  command_word,
    output lpddr_pkg::mem_op_t           op
);

    logic [lpddr_pkg::CMD_W-1:0] cmd_hi_reg,   cmd_hi_next;
    logic [14:0]                 open_row_reg, open_row_next;
    logic [12:0]                 column_reg,   column_next;
    logic [2:0]                  bank_reg,     bank_next;
    lpddr_pkg::burst_mode_t      mode_reg,     mode_next;
    logic [lpddr_pkg::LAT_W-1:0] lat_cnt_reg,  lat_cnt_next;
    logic [3:0]                  beats_reg,    beats_next;
    logic [lpddr_pkg::LAT_W-1:0] rl_reg,       rl_next;
    logic [lpddr_pkg::LAT_W-1:0] wl_reg,       wl_next;

    logic                        active;
    logic                        beat;
    logic [lpddr_pkg::POS_W-1:0] pos;
    logic [10:0]                 col_mix;
    logic [3:0]                  beats_dec;
    lpddr_pkg::latency_sel_t     mr_sel;

    always_comb
    begin
        case (mode_reg)
            lpddr_pkg::BURST_READ,
            lpddr_pkg::BURST_WRITE: active = 1'b1;
            default:                active = 1'b0;
        endcase
    end

    assign beat = active && (lat_cnt_reg == '0);

    // byte address modulo 2^28, word index drops the low bit
    assign pos = {open_row_reg, 13'b0}
               + {15'b0, bank_reg, 10'b0}
               + {15'b0, column_reg};

    assign op.rd   = beat && (mode_reg == lpddr_pkg::BURST_READ);
    assign op.wr   = beat && (mode_reg == lpddr_pkg::BURST_WRITE);
    assign op.addr = pos[lpddr_pkg::MEM_ADDR_BITS:1];

    assign col_mix   = {command_word[9:1], 2'b00} | {9'b0, command_word[6:5]};
    assign beats_dec = beats_reg - 4'd1;
    assign mr_sel    = lpddr_pkg::mr2_latency(command_word[5:2]);

    always_comb
    begin
        cmd_hi_next   = cmd_hi_reg;
        open_row_next = open_row_reg;
        column_next   = column_reg;
        bank_next     = bank_reg;
        mode_next     = mode_reg;
        lat_cnt_next  = lat_cnt_reg;
        beats_next    = beats_reg;
        rl_next       = rl_reg;
        wl_next       = wl_reg;

        if (!edge_phase)
        begin
            cmd_hi_next = command_word;
        end

        if (beat)
        begin
            // advance the burst by one word
            column_next = column_reg + 13'd2;
            beats_next  = beats_dec;
            if (beats_dec == '0)
            begin
                mode_next = lpddr_pkg::BURST_IDLE;
            end
        end
        else if (!edge_phase)
        begin
            if (lat_cnt_reg != '0)
            begin
                lat_cnt_next = lat_cnt_reg - 5'd1;
            end
        end
        else
        begin
            case (cmd_hi_reg[2:0])
                lpddr_pkg::CMD_NOP:
                begin
                    if (lat_cnt_reg != '0)
                    begin
                        lat_cnt_next = lat_cnt_reg - 5'd1;
                    end
                end
                lpddr_pkg::CMD_READ:
                begin
                    column_next  = {1'b0, col_mix, 1'b0};
                    bank_next    = cmd_hi_reg[9:7];
                    lat_cnt_next = rl_reg;
                    mode_next    = lpddr_pkg::BURST_READ;
                    beats_next   = lpddr_pkg::BURST_LEN;
                end
                lpddr_pkg::CMD_WRITE:
                begin
                    column_next  = {1'b0, col_mix, 1'b0};
                    bank_next    = cmd_hi_reg[9:7];
                    lat_cnt_next = wl_reg;
                    mode_next    = lpddr_pkg::BURST_WRITE;
                    beats_next   = lpddr_pkg::BURST_LEN;
                end
                lpddr_pkg::CMD_ACT_A,
                lpddr_pkg::CMD_ACT_B:
                begin
                    open_row_next = {cmd_hi_reg[6:2], command_word};
                end
                lpddr_pkg::CMD_MRW:
                begin
                    if (!cmd_hi_reg[3]
                        && ({command_word[1:0], cmd_hi_reg[9:4]} == lpddr_pkg::MR_LATENCY)
                        && mr_sel.hit)
                    begin
                        rl_next = mr_sel.rl;
                        wl_next = mr_sel.wl;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_hi_reg   <= '0;
            open_row_reg <= '0;
            column_reg   <= '0;
            bank_reg     <= '0;
            mode_reg     <= lpddr_pkg::BURST_IDLE;
            lat_cnt_reg  <= '0;
            beats_reg    <= '0;
            rl_reg       <= lpddr_pkg::RL_RESET;
            wl_reg       <= lpddr_pkg::WL_RESET;
        end
        else if (accept)
        begin
            cmd_hi_reg   <= cmd_hi_next;
            open_row_reg <= open_row_next;
            column_reg   <= column_next;
            bank_reg     <= bank_next;
            mode_reg     <= mode_next;
            lat_cnt_reg  <= lat_cnt_next;
            beats_reg    <= beats_next;
            rl_reg       <= rl_next;
            wl_reg       <= wl_next;
        end
    end

endmodule

### design/lpddr_sdram_device_model.sv
// ----------------------------------------------------------------------------
// lpddr_sdram_device_model : LPDDR SDRAM device model, one word per DDR edge
// Decodes the command bus and moves burst data to and from the memory array.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one DDR edge per word:
//   edge_phase, command_word and write_data. Output channel
//   (out_valid/out_ready) returns one read_data word for every input word,
//   in order: the memory word on a read beat, the echoed write_data otherwise.
//   Throughput is one word per cycle while the receiver keeps out_ready
//   high. From input acceptance a word passes the in-flight stage, which
//   waits for the registered memory read, and then the output register.
//   The memory array is one synchronous RAM of 2^MEM_ADDR_BITS words; a
//   write beat writes it in the accepting cycle, a read beat reads it then.
//   Read and write beats never fall on the same word, and any read command
//   has a nonzero latency, so a write always lands before a later read.
//   Reset clears the command and burst state and restores the default read
//   and write latencies; the memory contents are not cleared.
//   When the receiver stalls, the output register and the in-flight stage
//   hold their words and in_ready drops once both are full.
// ----------------------------------------------------------------------------
module lpddr_sdram_device_model (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         edge_phase,
    input  logic [lpddr_pkg::CMD_W-1:0]  command_word,
    input  logic [lpddr_pkg::DATA_W-1:0] write_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [lpddr_pkg::DATA_W-1:0] read_data
);

    logic                         accept;
    lpddr_pkg::mem_op_t           op;
    logic [lpddr_pkg::DATA_W-1:0] ram_rdata;

    // in-flight stage: waits for the registered RAM read
    logic                         s1_valid_reg;
    logic                         s1_is_rd_reg;
    logic [lpddr_pkg::DATA_W-1:0] s1_data_reg;
    logic                         s1_move;

    // output register
    logic                         out_valid_reg;
    logic [lpddr_pkg::DATA_W-1:0] out_data_reg;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;
    assign accept   = in_valid && in_ready;

    lpddr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .edge_phase   (edge_phase),
        .command_word (command_word),
        .op           (op)
    );

    // RAM read data only changes on a new accept, so it holds while s1 stalls
    lpddr_ram #(
        .WIDTH (lpddr_pkg::DATA_W),
        .DEPTH (lpddr_pkg::MEM_DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (accept && op.wr),
        .wr_addr (op.addr),
        .wr_data (write_data),
        .rd_en   (accept && op.rd),
        .rd_addr (op.addr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: capture on accept, pick RAM data or echo on the move to output
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_is_rd_reg <= op.rd;
            s1_data_reg  <= write_data;
        end
        if (s1_move)
        begin
            out_data_reg <= s1_is_rd_reg ? ram_rdata : s1_data_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = out_data_reg;

endmodule

### sim/lpddr_sdram_device_model_tb.sv
// ----------------------------------------------------------------------------
// lpddr_sdram_device_model_tb : self-checking bench for the LPDDR device model
// Drives DDR edge words (phase, command, data) through the valid/ready input,
// predicts every returned read_data word with a cycle-free model of the
// command decoder, latency counter and burst engine, and compares in order.
// A short directed table runs first, then randomised bursts, mode register
// writes, restarts and noise, with random idling on both channels.
// ----------------------------------------------------------------------------
module lpddr_sdram_device_model_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lpddr_pkg::*;

    // Command codes that the decoder must ignore
    localparam logic [2:0] CMD_SPARE_A = 3'd3;
    localparam logic [2:0] CMD_SPARE_B = 3'd4;

    localparam int RANDOM_WORDS = 1500;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_CAP    = 40;

    // One DDR edge as seen on the input channel
    typedef struct packed {
        logic              phase;
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] data;
    } ddr_word_t;

    // Directed row: the edge, plus a hand-written result where one is obvious
    typedef struct packed {
        logic              phase;
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] data;
        logic              typed;
        logic [DATA_W-1:0] want;
    } plan_row_t;

    // Address of a write burst, kept so that later reads can land on it
    typedef struct packed {
        logic [14:0]      row;
        logic [2:0]       bank;
        logic [CMD_W-1:0] lo;
    } spot_t;

    // Device state as the predictor sees it
    typedef struct {
        logic [CMD_W-1:0] hi;
        logic [CMD_W-1:0] lo;
        logic [14:0]      row;
        logic [12:0]      col;
        logic [2:0]       bank;
        burst_mode_t      mode;
        logic [LAT_W-1:0] lat;
        logic [3:0]       beats;
        logic [LAT_W-1:0] rl;
        logic [LAT_W-1:0] wl;
    } dram_state_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                edge_phase;
    logic [CMD_W-1:0]    command_word;
    logic [DATA_W-1:0]   write_data;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [DATA_W-1:0]   read_data;

    // Predictor: device state and memory image with a written map
    dram_state_t         dram;
    logic [DATA_W-1:0]   mem_img [MEM_DEPTH];
    bit                  written [MEM_DEPTH];

    logic [DATA_W-1:0]   read_data_due [$];
    spot_t               spots [$];
    plan_row_t           plan [25];

    bit                  steady = 1'b0;
    bit                  out_take = 1'b0;
    logic [DATA_W-1:0]   out_word;
    logic [DATA_W-1:0]   due_word;

    int                  n_sent = 0;
    int                  n_checked = 0;
    int                  n_errors = 0;
    int                  n_read_beats = 0;
    int                  n_write_beats = 0;
    int                  n_mr_updates = 0;
    int                  n_cycles = 0;

    lpddr_sdram_device_model u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .edge_phase   (edge_phase),
        .command_word (command_word),
        .write_data   (write_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_data    (read_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Column is the low command part rearranged into an even 13-bit value
    function automatic logic [12:0] column_of(input logic [CMD_W-1:0] lo);
        return {1'b0, lo[9:1], lo[6:5], 1'b0};
    endfunction

    // Byte position wraps at 2^28; the word index drops bit 0 and keeps
    // MEM_ADDR_BITS bits above it
    function automatic logic [MEM_ADDR_BITS-1:0] word_index(input logic [14:0] row,
                                                            input logic [2:0]  bank,
                                                            input logic [12:0] col);
        logic [POS_W-1:0] pos;
        pos = POS_W'({row, 13'd0}) + POS_W'({bank, 10'd0}) + POS_W'(col);
        return pos[MEM_ADDR_BITS:1];
    endfunction

    function automatic bit beat_due();
        return (dram.mode == BURST_READ || dram.mode == BURST_WRITE) && dram.lat == '0;
    endfunction

    // True when every word of an eight-beat burst has been written before
    function automatic bit burst_safe(input logic [14:0] row, input logic [2:0] bank,
                                      input logic [12:0] col);
        for (int k = 0; k < int'(BURST_LEN); k++)
            if (!written[word_index(row, bank, col + 13'(2 * k))])
                return 1'b0;
        return 1'b1;
    endfunction

    // Decode the latched command pair on a second-half edge
    function automatic void decode_pair();
        case (dram.hi[2:0])
            CMD_NOP:
                if (dram.lat != '0)
                    dram.lat -= 1'b1;
            CMD_READ, CMD_WRITE:
            begin
                dram.col   = column_of(dram.lo);
                dram.bank  = dram.hi[9:7];
                dram.beats = BURST_LEN;
                if (dram.hi[2:0] == CMD_READ)
                begin
                    dram.lat  = dram.rl;
                    dram.mode = BURST_READ;
                end
                else
                begin
                    dram.lat  = dram.wl;
                    dram.mode = BURST_WRITE;
                end
            end
            CMD_ACT_A, CMD_ACT_B:
                dram.row = {dram.hi[6:2], dram.lo};
            CMD_MRW:
                if (!dram.hi[3] && {dram.lo[1:0], dram.hi[9:4]} == MR_LATENCY)
                begin
                    // latency pairs per listed field value, all else ignored
                    case (dram.lo[5:2])
                        4'd1:
                        begin
                            dram.rl = 5'd6;
                            dram.wl = 5'd3;
                        end
                        4'd2:
                        begin
                            dram.rl = 5'd8;
                            dram.wl = 5'd5;
                        end
                        4'd3:
                        begin
                            dram.rl = 5'd10;
                            dram.wl = 5'd5;
                        end
                        4'd4:
                        begin
                            dram.rl = 5'd12;
                            dram.wl = 5'd7;
                        end
                        4'd5:
                        begin
                            dram.rl = 5'd14;
                            dram.wl = 5'd9;
                        end
                        4'd6:
                        begin
                            dram.rl = 5'd16;
                            dram.wl = 5'd9;
                        end
                        default: ;
                    endcase
                    if (dram.lo[5:2] inside {[4'd1:4'd6]})
                        n_mr_updates++;
                end
            default: ;
        endcase
    endfunction

    // Advance the device by one edge and return the word it sends back
    task automatic dram_edge(input ddr_word_t w, output logic [DATA_W-1:0] dout);
        logic [MEM_ADDR_BITS-1:0] idx;
        dout = w.data;
        if (w.phase)
            dram.lo = w.cmd;
        else
            dram.hi = w.cmd;
        if (beat_due())
        begin
            // data beat: no decode, no countdown
            idx = word_index(dram.row, dram.bank, dram.col);
            if (dram.mode == BURST_READ)
            begin
                dout = mem_img[idx];
                n_read_beats++;
            end
            else
            begin
                mem_img[idx] = w.data;
                written[idx] = 1'b1;
                n_write_beats++;
            end
            dram.col   += 13'd2;
            dram.beats -= 4'd1;
            if (dram.beats == '0)
                dram.mode = BURST_IDLE;
        end
        else if (!w.phase)
        begin
            if (dram.lat != '0)
                dram.lat -= 1'b1;
        end
        else
            decode_pair();
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        if (n_errors < PRINT_CAP)
            $display("MISMATCH at %0t ns: %s", $time, what);
        n_errors++;
    endtask

    // Sample the output handshake mid-cycle, where nothing is changing
    always @(negedge clk)
    begin
        out_take = rst_n && out_valid && out_ready;
        out_word = read_data;
    end

    // Compare each word taken at this edge with the oldest prediction, then
    // decide whether to stall the next cycle
    always @(posedge clk)
    begin
        if (out_take)
        begin
            if (read_data_due.size() == 0)
                report_mismatch($sformatf("word %h with nothing expected", out_word));
            else
            begin
                due_word = read_data_due.pop_front();
                if (out_word !== due_word)
                    report_mismatch($sformatf("read_data %h, expected %h (word %0d)",
                                              out_word, due_word, n_checked));
                n_checked++;
            end
        end
        out_ready <= steady || ($urandom_range(99) >= 30);
    end

    // Watchdog
    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d words still expected",
                     n_cycles, read_data_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    function automatic ddr_word_t mk_word(input logic p, input logic [CMD_W-1:0] c,
                                          input logic [DATA_W-1:0] d);
        ddr_word_t w;
        w.phase = p;
        w.cmd   = c;
        w.data  = d;
        return w;
    endfunction

    // Drop a second-half edge back to a first-half NOP if its decode would
    // lead to a read of words never written: a read command onto such words,
    // or an activate that moves a pending read onto them
    function automatic ddr_word_t make_safe(input ddr_word_t w);
        logic [2:0] code;
        code = dram.hi[2:0];
        if (w.phase && !beat_due())
        begin
            if ((code == CMD_READ &&
                 !burst_safe(dram.row, dram.hi[9:7], column_of(w.cmd))) ||
                ((code == CMD_ACT_A || code == CMD_ACT_B) && dram.mode == BURST_READ &&
                 !burst_safe({dram.hi[6:2], w.cmd}, dram.bank, dram.col)))
            begin
                w.phase = 1'b0;
                w.cmd   = {w.cmd[9:3], CMD_NOP};
            end
        end
        return w;
    endfunction

    // Present one word, hold it until taken, then predict its result.
    // Returns in the time step of acceptance so the next word can follow
    // without valid dropping.
    task automatic send_word(input ddr_word_t w, input bit typed,
                             input logic [DATA_W-1:0] want);
        int                gap;
        bit                took;
        logic [DATA_W-1:0] dout;
        gap = 0;
        if (!steady)
            while ($urandom_range(99) < 30)
                gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        edge_phase   <= w.phase;
        command_word <= w.cmd;
        write_data   <= w.data;
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        while (!took);
        dram_edge(w, dout);
        read_data_due.push_back(typed ? want : dout);
        n_sent++;
    endtask

    task automatic send_rand(input ddr_word_t w);
        send_word(make_safe(w), 1'b0, '0);
    endtask

    // Activate a row and issue a read or write; reads mostly revisit a
    // burst written earlier
    task automatic open_burst(input bit is_read);
        logic [14:0]      row;
        logic [2:0]       bank;
        logic [CMD_W-1:0] lo;
        int               pick;
        row  = 15'($urandom);
        bank = 3'($urandom);
        lo   = 10'($urandom);
        if (is_read && spots.size() != 0 && $urandom_range(9) < 8)
        begin
            pick = $urandom_range(spots.size() - 1);
            row  = spots[pick].row;
            bank = spots[pick].bank;
            lo   = spots[pick].lo;
        end
        else if (!is_read)
        begin
            spots.push_back({row, bank, lo});
            if (spots.size() > 64)
                void'(spots.pop_front());
        end
        // activate code 2 or 6 follows from row bit 10
        send_rand(mk_word(1'b0, {3'($urandom), row[14:10], 2'b10}, 16'($urandom)));
        send_rand(mk_word(1'b1, row[9:0], 16'($urandom)));
        send_rand(mk_word(1'b0, {bank, 4'($urandom), is_read ? CMD_READ : CMD_WRITE},
                          16'($urandom)));
        send_rand(mk_word(1'b1, lo, 16'($urandom)));
    endtask

    // Count the latency out with NOP pairs, then run the data beats with
    // random phases and bus contents
    task automatic finish_burst();
        while (dram.mode != BURST_IDLE && dram.lat != '0)
        begin
            send_rand(mk_word(1'b0, {7'($urandom), CMD_NOP}, 16'($urandom)));
            if (dram.lat != '0)
                send_rand(mk_word(1'b1, 10'($urandom), 16'($urandom)));
        end
        while (dram.mode != BURST_IDLE)
            send_rand(mk_word(1'($urandom), 10'($urandom), 16'($urandom)));
    endtask

    initial
    begin
        int               pick;
        int               spare;
        bit               flip;
        bit               held;
        logic [7:0]       mr_reg;
        logic [3:0]       mr_val;
        logic [CMD_W-1:0] spare_hi;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        edge_phase   = 1'b0;
        command_word = '0;
        write_data   = '0;
        held         = 1'b0;

        dram.hi    = '0;
        dram.lo    = '0;
        dram.row   = '0;
        dram.col   = '0;
        dram.bank  = '0;
        dram.mode  = BURST_IDLE;
        dram.lat   = '0;
        dram.beats = '0;
        dram.rl    = RL_RESET;
        dram.wl    = WL_RESET;

        // Directed table: phase, command, data, typed flag, typed result.
        // Command and idle edges echo the bus; the burst beats are predicted.
        plan = '{
            {1'b0, 10'h3FF, 16'h0000, 1'b1, 16'h0000},  // idle NOP, data all low
            {1'b1, 10'h3FF, 16'hFFFF, 1'b1, 16'hFFFF},  // NOP decode, data all high
            {1'b0, 10'h020, 16'hA5A5, 1'b1, 16'hA5A5},  // mode write, register two
            {1'b1, 10'h004, 16'h5A5A, 1'b1, 16'h5A5A},  // value one: shortest latencies
            {1'b0, 10'h028, 16'h0001, 1'b1, 16'h0001},  // mode write with bit 3 set
            {1'b1, 10'h018, 16'h8000, 1'b1, 16'h8000},  // ... ignored
            {1'b0, 10'h030, 16'h7FFF, 1'b1, 16'h7FFF},  // mode write, register three
            {1'b1, 10'h018, 16'h0002, 1'b1, 16'h0002},  // ... ignored
            {1'b0, 10'h3FE, 16'h1234, 1'b1, 16'h1234},  // activate, top row bits
            {1'b1, 10'h3FF, 16'h4321, 1'b1, 16'h4321},  // row 0x7FFF
            {1'b0, 10'h385, 16'h0000, 1'b1, 16'h0000},  // read, bank 7
            {1'b1, 10'h3FF, 16'hFFFF, 1'b1, 16'hFFFF},  // read latency loaded
            {1'b0, 10'h381, 16'h1111, 1'b1, 16'h1111},  // count down, write high part
            {1'b1, 10'h3FF, 16'h2222, 1'b1, 16'h2222},  // write restarts the burst
            {1'b0, 10'h3FF, 16'h3333, 1'b1, 16'h3333},  // count down
            {1'b1, 10'h000, 16'h4444, 1'b1, 16'h4444},  // NOP decode counts down
            {1'b0, 10'h3FC, 16'h6666, 1'b1, 16'h6666},  // spare code, latency out
            {1'b1, 10'h3FF, 16'hFFFF, 1'b0, 16'h0000},  // write beats; position
            {1'b0, 10'h385, 16'h0000, 1'b0, 16'h0000},  // wraps past 2^28, and a
            {1'b1, 10'h3FF, 16'h5555, 1'b0, 16'h0000},  // read command mid-burst
            {1'b0, 10'h3FF, 16'hAAAA, 1'b0, 16'h0000},  // is ignored
            {1'b1, 10'h000, 16'h8001, 1'b0, 16'h0000},
            {1'b0, 10'h000, 16'h7FFE, 1'b0, 16'h0000},
            {1'b1, 10'h155, 16'h0F0F, 1'b0, 16'h0000},
            {1'b0, 10'h2AA, 16'hF0F0, 1'b0, 16'h0000}
        };

        // Hold reset low at the start, release it on a rising edge
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_word(mk_word(plan[i].phase, plan[i].cmd, plan[i].data),
                      plan[i].typed, plan[i].want);

        while (n_sent < $size(plan) + RANDOM_WORDS)
        begin
            // a stretch with no idling on either side
            steady = (n_sent >= 500 && n_sent < 800);

            // once, hold the sender until every prediction has been matched
            if (!held && n_sent >= 1000)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (read_data_due.size() != 0)
                    @(posedge clk);
                held = 1'b1;
            end

            pick = $urandom_range(99);
            if (pick < 35)
            begin
                open_burst(1'b0);
                finish_burst();
            end
            else if (pick < 68)
            begin
                open_burst(1'b1);
                finish_burst();
            end
            else if (pick < 78)
            begin
                // mode register write, mostly register two with a valid value
                mr_reg = ($urandom_range(9) < 8) ? MR_LATENCY : 8'($urandom);
                mr_val = ($urandom_range(9) < 7) ? 4'($urandom_range(6, 1)) : 4'($urandom);
                send_rand(mk_word(1'b0, {mr_reg[5:0], 1'b0, CMD_MRW}, 16'($urandom)));
                send_rand(mk_word(1'b1, {4'($urandom), mr_val, mr_reg[7:6]},
                                  16'($urandom)));
            end
            else if (pick < 86)
            begin
                // second burst opened right behind the first, which may still be counting its latency
                flip = 1'($urandom);
                open_burst(flip);
                send_rand(mk_word(1'b0, {7'($urandom), CMD_NOP}, 16'($urandom)));
                send_rand(mk_word(1'b1, 10'($urandom), 16'($urandom)));
                open_burst(!flip);
                finish_burst();
            end
            else if (pick < 92)
            begin
                // pairs the decoder must drop
                spare = $urandom_range(2);
                if (spare == 0)
                    spare_hi = {7'($urandom), CMD_SPARE_A};
                else if (spare == 1)
                    spare_hi = {7'($urandom), CMD_SPARE_B};
                else
                    spare_hi = {6'($urandom), 1'b1, CMD_MRW};
                send_rand(mk_word(1'b0, spare_hi, 16'($urandom)));
                send_rand(mk_word(1'b1, 10'($urandom), 16'($urandom)));
            end
            else
            begin
                // raw noise: any phase, any command, any data
                repeat ($urandom_range(4, 1))
                    send_rand(mk_word(1'($urandom), 10'($urandom), 16'($urandom)));
            end
        end

        // Stop sending, let the pipeline empty, then keep watching the output
        // for any stray word
        in_valid <= 1'b0;
        steady = 1'b0;
        @(posedge clk);
        while (read_data_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d DDR edges: %0d read beats, %0d write beats, %0d latency changes",
                 n_sent, n_read_beats, n_write_beats, n_mr_updates);
        $display("Compared %0d returned words, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
